/* rtl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, switched off while reset is low
`define ASSERT_PROP(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// overlapping implication checked on every rising edge
`define ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/utf8sd_pkg.sv */
// shared types, status codes and lookup functions of the utf-8 stream decoder
package utf8sd_pkg;

    localparam int CP_W  = 31;
    localparam int ST_W  = 3;
    localparam int LEN_W = 3;

    localparam logic [ST_W-1:0] ST_OK         = 3'd0;
    localparam logic [ST_W-1:0] ST_BAD_LEAD   = 3'd1;
    localparam logic [ST_W-1:0] ST_OVERLONG2  = 3'd2;
    localparam logic [ST_W-1:0] ST_BAD_CONT   = 3'd3;
    localparam logic [ST_W-1:0] ST_OVERLONG_N = 3'd4;
    localparam logic [ST_W-1:0] ST_TRUNCATED  = 3'd5;

    localparam logic [CP_W-1:0] CP_BOM   = 31'h0000_FEFF;
    localparam logic [CP_W-1:0] CP_BMP   = 31'h0000_FFFF;
    localparam logic [CP_W-1:0] CP_SPACE = 31'h0000_0020;

    typedef struct packed {
        logic [LEN_W-1:0] bytes_left;
        logic [LEN_W-1:0] seq_length;
        logic [CP_W-1:0]  acc;
        logic             at_start;
        logic             dropping;
    } dec_state_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            has_code;
        logic [ST_W-1:0] status;
        logic            end_of_string;
    } dec_result_t;

    // sequence length from the lead byte, zero for an invalid lead
    function automatic logic [LEN_W-1:0] lead_length(input logic [7:0] b);
        logic [LEN_W-1:0] len;
        if (b[7] == 1'b0)
            len = 3'd1;
        else if (b[7:5] == 3'b110)
            len = 3'd2;
        else if (b[7:4] == 4'b1110)
            len = 3'd3;
        else if (b[7:3] == 5'b11110)
            len = 3'd4;
        else if (b[7:2] == 6'b111110)
            len = 3'd5;
        else if (b[7:1] == 7'b1111110)
            len = 3'd6;
        else
            len = 3'd0;
        return len;
    endfunction

    // payload bits kept from the lead byte
    function automatic logic [7:0] lead_mask(input logic [LEN_W-1:0] len);
        logic [7:0] m;
        unique case (len)
            3'd2:    m = 8'h1F;
            3'd3:    m = 8'h0F;
            3'd4:    m = 8'h07;
            3'd5:    m = 8'h03;
            3'd6:    m = 8'h01;
            default: m = 8'h7F;
        endcase
        return m;
    endfunction

    // smallest value a sequence of three to six bytes may encode, zero for other lengths
    function automatic logic [CP_W-1:0] min_value(input logic [LEN_W-1:0] len);
        logic [CP_W-1:0] v;
        unique case (len)
            3'd3:    v = 31'h0000_0800;
            3'd4:    v = 31'h0001_0000;
            3'd5:    v = 31'h0020_0000;
            3'd6:    v = 31'h0400_0000;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/utf8sd_in_stage.sv */
// input register stage taking one byte per transaction
module utf8sd_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // is_last
    input  logic       advance,
    output logic       byte_valid,
    output logic [7:0] byte_data,
    output logic       byte_last
);

    logic       valid_reg;
    logic [7:0] data_reg;
    logic       last_reg;

    assign s_tready = !valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (s_tready)
            valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            data_reg <= s_tdata;
            last_reg <= s_tlast;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;
    assign byte_last  = last_reg;

endmodule

/* rtl/utf8sd_step.sv */
// decode step: one byte against the decoder state gives next state and result
module utf8sd_step (
    input  utf8sd_pkg::dec_state_t  cur,
    input  logic [7:0]              in_byte,
    input  logic                    is_last,
    input  logic                    replace_above_bmp,
    output utf8sd_pkg::dec_state_t  nxt,
    output utf8sd_pkg::dec_result_t res,
    output logic                    res_valid
);
    import utf8sd_pkg::*;

    logic [LEN_W-1:0] len;
    logic [CP_W-1:0]  acc_shift;
    logic [CP_W-1:0]  cp;
    logic             fail;
    logic [ST_W-1:0]  fail_st;
    logic             done;

    assign len       = lead_length(in_byte);
    assign acc_shift = {cur.acc[CP_W-7:0], in_byte[5:0]};

    always_comb
    begin
        nxt       = cur;
        res       = '0;
        res_valid = 1'b0;
        fail      = 1'b0;
        fail_st   = ST_OK;
        done      = 1'b0;
        cp        = '0;

        if (cur.dropping)
        begin
            if (is_last)
            begin
                nxt.dropping   = 1'b0;
                nxt.at_start   = 1'b1;
                nxt.bytes_left = '0;
                nxt.seq_length = '0;
                nxt.acc        = '0;
            end
        end
        else if (cur.bytes_left == '0)
        begin
            // a zero lead byte closes the string like an error with ok status
            if (in_byte == 8'h00)
                fail = 1'b1;
            else if (len == 3'd0)
            begin
                fail    = 1'b1;
                fail_st = ST_BAD_LEAD;
            end
            else if (len == 3'd2 && in_byte[4:1] == 4'h0)
            begin
                fail    = 1'b1;
                fail_st = ST_OVERLONG2;
            end
            else if (len == 3'd1)
            begin
                done = 1'b1;
                cp   = {{(CP_W-8){1'b0}}, in_byte};
            end
            else if (is_last)
            begin
                fail    = 1'b1;
                fail_st = ST_TRUNCATED;
            end
            else
            begin
                nxt.acc        = {{(CP_W-8){1'b0}}, in_byte & lead_mask(len)};
                nxt.bytes_left = len - 3'd1;
                nxt.seq_length = len;
            end
        end
        else
        begin
            if (in_byte == 8'h00 || (is_last && cur.bytes_left > 3'd1))
            begin
                fail    = 1'b1;
                fail_st = ST_TRUNCATED;
            end
            else if (in_byte[7:6] != 2'b10)
            begin
                fail    = 1'b1;
                fail_st = ST_BAD_CONT;
            end
            else
            begin
                nxt.acc        = acc_shift;
                nxt.bytes_left = cur.bytes_left - 3'd1;
                if (cur.bytes_left == 3'd1)
                begin
                    if (acc_shift < min_value(cur.seq_length))
                    begin
                        fail    = 1'b1;
                        fail_st = ST_OVERLONG_N;
                    end
                    else
                    begin
                        done           = 1'b1;
                        cp             = acc_shift;
                        nxt.bytes_left = '0;
                        nxt.seq_length = '0;
                        nxt.acc        = '0;
                    end
                end
            end
        end

        if (fail)
        begin
            res_valid         = 1'b1;
            res.status        = fail_st;
            res.end_of_string = 1'b1;
            nxt.bytes_left    = '0;
            nxt.seq_length    = '0;
            nxt.acc           = '0;
            nxt.dropping      = !is_last;
            nxt.at_start      = 1'b1;
        end
        else if (done)
        begin
            nxt.at_start = is_last;
            if (cur.at_start && cp == CP_BOM)
            begin
                // byte order mark dropped, only the end of string shows
                res_valid         = is_last;
                res.end_of_string = is_last;
            end
            else
            begin
                res_valid         = 1'b1;
                res.has_code      = 1'b1;
                res.code_point    = (replace_above_bmp && cp > CP_BMP) ? CP_SPACE : cp;
                res.end_of_string = is_last;
            end
        end
    end

endmodule

/* rtl/utf8sd_out_stage.sv */
// output register holding one result until the sink takes it
module utf8sd_out_stage (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  utf8sd_pkg::dec_result_t res,
    output logic                    room,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [31:0]             m_tdata,  // [30:0] code_point, [31] zero
    output logic [3:0]              m_tuser,  // [0] has_code, [3:1] status
    output logic                    m_tlast   // end_of_string
);
    import utf8sd_pkg::*;

    logic        valid_reg;
    dec_result_t res_reg;

    assign room = !valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (m_tready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, res_reg.code_point};
    assign m_tuser  = {res_reg.status, res_reg.has_code};
    assign m_tlast  = res_reg.end_of_string;

endmodule

/* rtl/utf8_stream_decoder_top.sv */
// top level of the utf-8 stream decoder
//
// Streaming UTF-8 decoder with validation. Bytes of a string arrive one per
// slave transaction (s_tdata = byte, s_tlast on the final byte); each decoded
// code point leaves as one master transaction once its last byte has been
// decoded, with has_code and status in m_tuser and m_tlast marking the result
// that closes the string or reports an error. Sequences of one to six bytes
// are handled; a leading byte order mark is dropped, a zero lead byte ends the
// string, and the first error of a string (bad lead, overlong two-byte form,
// bad continuation, overlong longer form, truncation) is reported once, after
// which bytes are discarded up to s_tlast. Code points are passed on as they
// complete, so a sink must throw away a string whose closing result carries a
// nonzero status. Throughput is one byte per clock cycle while the output
// register is not held full: the byte goes into an input register, the
// decode step runs combinationally against the sequence state, and the
// result lands in an output register. s_tready follows m_tready
// through both registers, so the block only stalls while the output register
// is full and not being taken. The one-bit replace_above_bmp register (written
// through cfg_valid/cfg_data, default 0) turns every code point above U+FFFF
// into a space; write it only while no string is in flight.
module utf8_stream_decoder_top (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,   // replace_above_bmp
    // byte stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    input  logic        s_tlast,    // is_last
    // code point stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [30:0] code_point, [31] zero
    output logic [3:0]  m_tuser,    // [0] has_code, [3:1] status
    output logic        m_tlast     // end_of_string
);
    import utf8sd_pkg::*;

    // handshake between the stages
    logic        byte_valid;
    logic [7:0]  byte_data;
    logic        byte_last;
    logic        room;
    logic        advance;

    // decoder state and step outputs
    dec_state_t  state_reg;
    dec_state_t  state_next;
    dec_result_t step_res;
    logic        step_res_valid;
    logic        replace_reg;

    // configuration register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            replace_reg <= 1'b0;
        else if (cfg_valid)
            replace_reg <= cfg_data;
    end

    // a buffered byte moves on when the output register can take its result
    assign advance = byte_valid && room;

    utf8sd_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .advance    (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .byte_last  (byte_last)
    );

    utf8sd_step u_step (
        .cur               (state_reg),
        .in_byte           (byte_data),
        .is_last           (byte_last),
        .replace_above_bmp (replace_reg),
        .nxt               (state_next),
        .res               (step_res),
        .res_valid         (step_res_valid)
    );

    // sequence state: reset puts the decoder at the start of a string
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '{bytes_left: '0, seq_length: '0, acc: '0,
                           at_start: 1'b1, dropping: 1'b0};
        else if (advance)
            state_reg <= state_next;
    end

    utf8sd_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance && step_res_valid),
        .res      (step_res),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

/* rtl/utf8sd_checker.sv */
// port-level checks on the decoder output, bound to the top level
`include "assert_macros.svh"

module utf8sd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [3:0]  m_tuser,
    input logic        m_tlast
);
    import utf8sd_pkg::*;

    // a stalled result keeps its payload
    `ASSERT_PROP(a_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")

    // results without a character always close the string
    `ASSERT_IMPL(a_nochar_last, clk, rst_n, m_tvalid && !m_tuser[0], m_tlast, "result without character did not close string")

    // results without a character carry a zero code point
    `ASSERT_IMPL(a_nochar_zero, clk, rst_n, m_tvalid && !m_tuser[0], m_tdata == 32'h0, "code point set on result without character")

    // a character is only ever delivered with ok status
    `ASSERT_IMPL(a_char_ok, clk, rst_n, m_tvalid && m_tuser[0], m_tuser[3:1] == ST_OK, "character delivered with error status")

    // the status code stays within the defined set
    `ASSERT_IMPL(a_status_range, clk, rst_n, m_tvalid, m_tuser[3:1] != 3'd6 && m_tuser[3:1] != 3'd7, "undefined status code")

endmodule

bind utf8_stream_decoder_top utf8sd_checker u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

/* tb/tb_utf8_stream_decoder_top.sv */
// self-checking testbench of the utf-8 stream decoder top level
module tb_utf8_stream_decoder_top;
    timeunit 1ns;
    timeprecision 1ps;

    import utf8sd_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int N_PHASES     = 5;
    localparam int PHASE_BYTES  = 250;
    localparam int SETTLE_CYCLES = 4;
    localparam int LONG_HOLD    = 400;

    // one row of the directed table: the byte, its last flag and, where the
    // outcome is plain, the result typed in by hand
    typedef struct {
        logic [7:0]  data;
        logic        last;
        bit          known;
        bit          gives;
        dec_result_t want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;     // [7:0] in_byte
    logic        s_tlast = 1'b0;      // is_last
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;             // [30:0] code_point, [31] zero
    logic [3:0]  m_tuser;             // [0] has_code, [3:1] status
    logic        m_tlast;             // end_of_string

    // side information travelling with each offered byte, seen at acceptance
    bit          row_known = 1'b0;
    bit          row_gives = 1'b0;
    dec_result_t row_want = '0;

    // decoder state mirrored by the predictor, reset values as after rst_n
    logic [2:0]  dec_left = 3'd0;
    logic [2:0]  dec_seq_len = 3'd0;
    logic [30:0] dec_acc = '0;
    logic        dec_at_start = 1'b1;
    logic        dec_dropping = 1'b0;
    logic        dec_replace = 1'b0;

    dec_result_t pending_codes[$];
    logic [7:0]  str_q[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          hold_left = 0;

    int phase_send_idle [N_PHASES] = '{0, 58, 0, 28, 0};
    int phase_stall     [N_PHASES] = '{0, 0, 58, 28, 0};
    bit phase_replace   [N_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};

    // directed table: plain ascii, a dropped byte order mark, every error
    // kind, the terminating zero, a lead flagged last and the widest code
    stim_row_t directed_rows [26] = '{
        '{8'h7F, 1'b1, 1'b1, 1'b1, '{31'h7F, 1'b1, ST_OK, 1'b1}},
        '{8'hEF, 1'b0, 1'b0, 1'b0, '0},
        '{8'hBB, 1'b0, 1'b0, 1'b0, '0},
        '{8'hBF, 1'b0, 1'b1, 1'b0, '0},
        '{8'h41, 1'b1, 1'b1, 1'b1, '{31'h41, 1'b1, ST_OK, 1'b1}},
        '{8'h80, 1'b0, 1'b1, 1'b1, '{31'h0, 1'b0, ST_BAD_LEAD, 1'b1}},
        '{8'h41, 1'b1, 1'b1, 1'b0, '0},
        '{8'hC0, 1'b1, 1'b1, 1'b1, '{31'h0, 1'b0, ST_OVERLONG2, 1'b1}},
        '{8'hFF, 1'b1, 1'b1, 1'b1, '{31'h0, 1'b0, ST_BAD_LEAD, 1'b1}},
        '{8'hE0, 1'b0, 1'b0, 1'b0, '0},
        '{8'h80, 1'b0, 1'b0, 1'b0, '0},
        '{8'h80, 1'b1, 1'b1, 1'b1, '{31'h0, 1'b0, ST_OVERLONG_N, 1'b1}},
        '{8'hC3, 1'b0, 1'b0, 1'b0, '0},
        '{8'h41, 1'b1, 1'b1, 1'b1, '{31'h0, 1'b0, ST_BAD_CONT, 1'b1}},
        '{8'hE2, 1'b0, 1'b0, 1'b0, '0},
        '{8'h82, 1'b1, 1'b1, 1'b1, '{31'h0, 1'b0, ST_TRUNCATED, 1'b1}},
        '{8'hF0, 1'b0, 1'b0, 1'b0, '0},
        '{8'h00, 1'b1, 1'b1, 1'b1, '{31'h0, 1'b0, ST_TRUNCATED, 1'b1}},
        '{8'h00, 1'b1, 1'b1, 1'b1, '{31'h0, 1'b0, ST_OK, 1'b1}},
        '{8'hC2, 1'b1, 1'b1, 1'b1, '{31'h0, 1'b0, ST_TRUNCATED, 1'b1}},
        '{8'hFD, 1'b0, 1'b0, 1'b0, '0},
        '{8'hBF, 1'b0, 1'b0, 1'b0, '0},
        '{8'hBF, 1'b0, 1'b0, 1'b0, '0},
        '{8'hBF, 1'b0, 1'b0, 1'b0, '0},
        '{8'hBF, 1'b0, 1'b0, 1'b0, '0},
        '{8'hBF, 1'b1, 1'b1, 1'b1, '{31'h7FFF_FFFF, 1'b1, ST_OK, 1'b1}}
    };

    utf8_stream_decoder_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // predictor of the decode step
    // ------------------------------------------------------------------

    function automatic void clear_sequence();
        dec_left    = 3'd0;
        dec_seq_len = 3'd0;
        dec_acc     = '0;
    endfunction

    // result that closes a string: terminating zero, lone byte order mark
    // flagged last, or any error; bytes are then skipped unless this was last
    function automatic bit close_string(input logic [2:0] st, input logic last,
                                        output dec_result_t r);
        r = '0;
        r.status        = st;
        r.end_of_string = 1'b1;
        clear_sequence();
        dec_dropping = !last;
        dec_at_start = 1'b1;
        return 1'b1;
    endfunction

    // advances the mirrored state by one byte; returns 1 when a result is due
    function automatic bit decode_byte(input logic [7:0] b, input logic last,
                                       output dec_result_t r);
        logic [30:0] cp;
        logic [30:0] floor_v;
        int          n;
        r = '0;
        cp = '0;
        n = 0;
        if (dec_dropping) begin
            if (last) begin
                dec_dropping = 1'b0;
                dec_at_start = 1'b1;
                clear_sequence();
            end
            return 1'b0;
        end
        if (dec_left == 3'd0) begin
            if (b == 8'h00)
                return close_string(ST_OK, last, r);
            casez (b)
                8'b0???????: n = 1;
                8'b110?????: n = 2;
                8'b1110????: n = 3;
                8'b11110???: n = 4;
                8'b111110??: n = 5;
                8'b1111110?: n = 6;
                default:     return close_string(ST_BAD_LEAD, last, r);
            endcase
            // two-byte lead carrying fewer than eight payload bits
            if (n == 2 && b[4:1] == 4'b0000)
                return close_string(ST_OVERLONG2, last, r);
            if (n == 1) begin
                cp = {23'b0, b};
            end else begin
                if (last)
                    return close_string(ST_TRUNCATED, last, r);
                dec_acc     = {23'b0, b & (8'hFF >> (n + 1))};
                dec_left    = 3'(n - 1);
                dec_seq_len = 3'(n);
                return 1'b0;
            end
        end else begin
            // a zero byte or a last flag that leaves bytes missing wins over
            // a malformed continuation
            if (b == 8'h00 || (last && dec_left > 3'd1))
                return close_string(ST_TRUNCATED, last, r);
            if (b[7:6] != 2'b10)
                return close_string(ST_BAD_CONT, last, r);
            dec_acc  = {dec_acc[24:0], b[5:0]};
            dec_left = dec_left - 3'd1;
            if (dec_left != 3'd0)
                return 1'b0;
            cp = dec_acc;
            case (dec_seq_len)
                3'd3:    floor_v = 31'h0000_0800;
                3'd4:    floor_v = 31'h0001_0000;
                3'd5:    floor_v = 31'h0020_0000;
                3'd6:    floor_v = 31'h0400_0000;
                default: floor_v = '0;
            endcase
            if (cp < floor_v)
                return close_string(ST_OVERLONG_N, last, r);
            clear_sequence();
        end
        // byte order mark as first code point of a string is swallowed
        if (dec_at_start && cp == CP_BOM) begin
            if (last)
                return close_string(ST_OK, last, r);
            dec_at_start = 1'b0;
            return 1'b0;
        end
        dec_at_start = last;
        if (dec_replace && cp > CP_BMP)
            cp = CP_SPACE;
        r.code_point    = cp;
        r.has_code      = 1'b1;
        r.end_of_string = last;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // random string builder
    // ------------------------------------------------------------------

    // smallest code point that needs n bytes (ascii starts at 1, not 0)
    function automatic int unsigned code_floor(input int n);
        case (n)
            1:       return 32'h0000_0001;
            2:       return 32'h0000_0080;
            3:       return 32'h0000_0800;
            4:       return 32'h0001_0000;
            5:       return 32'h0020_0000;
            default: return 32'h0400_0000;
        endcase
    endfunction

    function automatic int unsigned code_ceiling(input int n);
        return (n == 6) ? 32'h7FFF_FFFF : code_floor(n + 1) - 1;
    endfunction

    function automatic void append_encoded(input logic [30:0] cp, input int n);
        logic [7:0] lead;
        int         k;
        lead = (n == 1) ? 8'h00 : 8'(8'hFF << (8 - n));
        str_q.push_back(lead | 8'(cp >> (6 * (n - 1))));
        for (k = n - 2; k >= 0; k--)
            str_q.push_back(8'h80 | 8'((cp >> (6 * k)) & 31'h3F));
    endfunction

    // mostly short forms, a few five and six byte ones, and boundary values
    // around surrogates, the byte order mark and the end of the bmp
    function automatic void append_random_char(input bit overlong);
        int          n;
        int          pick;
        logic [30:0] cp;
        pick = $urandom_range(19);
        if (pick < 8)
            n = 1;
        else if (pick < 12)
            n = 2;
        else if (pick < 15)
            n = 3;
        else if (pick < 17)
            n = 4;
        else if (pick == 17)
            n = 5;
        else
            n = 6;
        cp = 31'($urandom_range(code_ceiling(n), code_floor(n)));
        if (overlong) begin
            n  = $urandom_range(6, 2);
            cp = 31'($urandom_range(code_floor(n) - 1, 0));
        end else if (pick == 19) begin
            case ($urandom_range(5))
                0: begin cp = CP_BOM; n = 3; end
                1: begin cp = 31'($urandom_range(32'hDFFF, 32'hD800)); n = 3; end
                2: begin cp = CP_BMP; n = 3; end
                3: begin cp = 31'h0001_0000; n = 4; end
                4: begin cp = 31'h0010_FFFF; n = 4; end
                default: begin cp = 31'h0011_0000; n = 4; end
            endcase
        end
        append_encoded(cp, n);
    endfunction

    // about three quarters well-formed strings, the rest broken or noise
    function automatic void make_string();
        int kind;
        int pos;
        str_q.delete();
        kind = $urandom_range(99);
        if (kind < 8) begin
            repeat ($urandom_range(4, 1))
                str_q.push_back(8'($urandom_range(255)));
        end else begin
            if ($urandom_range(9) == 0)
                append_encoded(CP_BOM, 3);
            repeat ($urandom_range(6, 0))
                append_random_char(1'b0);
            if (str_q.size() == 0)
                append_encoded(CP_BOM, 3);
            if (kind < 28) begin
                pos = $urandom_range(str_q.size() - 1);
                case ($urandom_range(4))
                    0: str_q[pos] = 8'($urandom_range(255));
                    1: if (str_q.size() > 1) str_q.delete(str_q.size() - 1);
                    2: append_random_char(1'b1);
                    3: str_q.insert(pos, 8'h00);
                    default: str_q.insert(pos, 8'($urandom_range(255)));
                endcase
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // offers one byte after a random idle stretch and returns at its acceptance
    task automatic push_byte(input logic [7:0] b, input logic last, input bit known,
                             input bit gives, input dec_result_t want);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= b;
        s_tlast   <= last;
        row_known <= known;
        row_gives <= gives;
        row_want  <= want;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic write_replace(input logic v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // sender pauses until every code point is back and the pipe is empty;
    // a clock edge is awaited first so the last accepted byte has been predicted
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_codes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // receiver: random stalls plus one long hold-off counted here
    // ------------------------------------------------------------------

    always @(posedge clk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // prediction at input acceptance, checking at output acceptance
    // ------------------------------------------------------------------

    function automatic void note_mismatch(input string field, input longint unsigned want,
                                          input longint unsigned got);
        $display("%0t mismatch on %s: expected %0h, actual %0h", $time, field, want, got);
        mismatch_count++;
    endfunction

    always @(posedge clk) begin
        dec_result_t pred;
        dec_result_t exp_res;
        bit          due;
        if (rst_n) begin
            if (cfg_valid && cfg_ready)
                dec_replace = cfg_data;
            if (s_tvalid && s_tready) begin
                due = decode_byte(s_tdata, s_tlast, pred);
                // hand-typed rows override the predictor outcome
                if (row_known) begin
                    due  = row_gives;
                    pred = row_want;
                end
                if (due)
                    pending_codes.push_back(pred);
            end
            if (m_tvalid && m_tready) begin
                if (pending_codes.size() == 0) begin
                    $display("%0t unexpected transaction: expected none, actual code %0h user %0h last %0b",
                             $time, m_tdata, m_tuser, m_tlast);
                    mismatch_count++;
                end else begin
                    exp_res = pending_codes.pop_front();
                    if (m_tdata[30:0] !== exp_res.code_point)
                        note_mismatch("code_point", exp_res.code_point, m_tdata[30:0]);
                    if (m_tuser[0] !== exp_res.has_code)
                        note_mismatch("has_code", exp_res.has_code, m_tuser[0]);
                    if (m_tuser[3:1] !== exp_res.status)
                        note_mismatch("status", exp_res.status, m_tuser[3:1]);
                    if (m_tlast !== exp_res.end_of_string)
                        note_mismatch("end_of_string", exp_res.end_of_string, m_tlast);
                end
            end
        end
    end

    // watchdog on the whole run
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL utf8_stream_decoder_top");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial begin
        int p;
        int i;
        int sent;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part under the reset value of replace_above_bmp
        for (i = 0; i < $size(directed_rows); i++)
            push_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].known,
                      directed_rows[i].gives, directed_rows[i].want);
        drain();

        // random phases, each setting its register value and idling pattern
        for (p = 0; p < N_PHASES; p++) begin
            send_idle_pct = phase_send_idle[p];
            stall_pct     = phase_stall[p];
            write_replace(phase_replace[p]);
            // last phase: receiver holds off while bytes keep coming
            if (p == N_PHASES - 1)
                hold_left = LONG_HOLD;
            sent = 0;
            while (sent < PHASE_BYTES) begin
                make_string();
                for (i = 0; i < str_q.size(); i++)
                    push_byte(str_q[i], i == str_q.size() - 1, 1'b0, 1'b0, '0);
                sent += str_q.size();
            end
            // terminating zero flagged last leaves no string in flight
            push_byte(8'h00, 1'b1, 1'b0, 1'b0, '0);
            drain();
        end

        if (mismatch_count == 0)
            $display("PASS utf8_stream_decoder_top");
        else
            $display("FAIL utf8_stream_decoder_top");
        $finish;
    end

endmodule
